[rtl/stbs_pkg.sv]
// Shared constants and types for the sorted-table binary search block.
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int RNG_W       = IDX_W + 1;
  localparam int KEY_W       = 32;

  // Request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

[rtl/stbs_req_if.sv]
// Request channel: valid/ready handshake with load and search payload.
`default_nettype none

interface stbs_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic        [stbs_pkg::IDX_W-1:0]   entry_index;
  logic signed [stbs_pkg::KEY_W-1:0]   key_value;
  logic        [stbs_pkg::RNG_W-1:0]   range_start;
  logic        [stbs_pkg::RNG_W-1:0]   range_end;

  modport source (output valid, req_type, entry_index, key_value, range_start, range_end,
                  input ready);
  modport sink   (input valid, req_type, entry_index, key_value, range_start, range_end,
                  output ready);
endinterface

`default_nettype wire

[rtl/stbs_rsp_if.sv]
// Result channel: valid/ready handshake with search outcome payload.
`default_nettype none

interface stbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [stbs_pkg::IDX_W-1:0]    match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

`default_nettype wire

[rtl/sorted_table_binary_search.sv]
// Top level: table memory plus sequential binary search controller.
//
//  channel   dir  handshake              payload
//  in_req    in   valid / ready          req_type, entry_index, key_value,
//                                        range_start, range_end
//  out_rsp   out  valid / ready          found, match_index
//
// A load request writes the table and produces no result. A search request first sets
// up the window and issues the first read, then runs one probe after another (at most
// 11 for 1024 entries): each probe is one table read and a compare on its data.
// Reset (rst_n, synchronous, active low) clears control state only; the table is
// undefined until written. A stalled result holds in the output register while the
// next request is taken; a second result then waits in the done state until it frees.
`default_nettype none

module sorted_table_binary_search (
  input  wire logic   clk,
  input  wire logic   rst_n,
  stbs_req_if.sink    in_req,
  stbs_rsp_if.source  out_rsp
);

  localparam logic [stbs_pkg::RNG_W-1:0] DEPTH_R = stbs_pkg::RNG_W'(stbs_pkg::TABLE_DEPTH);

  stbs_pkg::state_t state_r, state_nxt;

  logic        [stbs_pkg::RNG_W-1:0] lo_r, lo_nxt;    // inclusive low bound
  logic        [stbs_pkg::RNG_W-1:0] he_r, he_nxt;    // exclusive high bound
  logic        [stbs_pkg::IDX_W-1:0] mid_r, mid_nxt;  // address being probed
  logic signed [stbs_pkg::KEY_W-1:0] key_r, key_nxt;

  logic                              res_found_r, res_found_nxt;
  logic        [stbs_pkg::IDX_W-1:0] res_idx_r, res_idx_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_found_r, out_found_nxt;
  logic        [stbs_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic                              ram_we;
  logic        [stbs_pkg::KEY_W-1:0] ram_rdata;

  logic                              req_fire;
  logic                              slot_free;
  logic        [stbs_pkg::RNG_W-1:0] start_sat, end_sat;
  logic        [stbs_pkg::RNG_W-1:0] span;
  logic        [stbs_pkg::RNG_W-1:0] mid_wide;
  logic                              finish;
  logic                              fin_found;
  logic        [stbs_pkg::IDX_W-1:0] fin_idx;

  assign in_req.ready = (state_r == stbs_pkg::ST_IDLE);
  assign req_fire     = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_rsp.ready;

  // Clamp the window to the table.
  assign start_sat = (in_req.range_start > DEPTH_R) ? DEPTH_R : in_req.range_start;
  assign end_sat   = (in_req.range_end   > DEPTH_R) ? DEPTH_R : in_req.range_end;

  // Midpoint of the next window: lo + (hi_incl - lo) / 2, only used when lo < he.
  assign span     = he_nxt - lo_nxt - stbs_pkg::RNG_W'(1);
  assign mid_wide = lo_nxt + (span >> 1);

  // Loads write straight into the table; indexes beyond the depth drop.
  assign ram_we = req_fire && (in_req.req_type == stbs_pkg::REQ_LOAD) &&
                  ({1'b0, in_req.entry_index} < DEPTH_R);

  stbs_ram #(
    .WIDTH (stbs_pkg::KEY_W),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_req.entry_index),
    .wdata (in_req.key_value),
    .raddr (mid_nxt),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    he_nxt        = he_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    finish        = 1'b0;
    fin_found     = 1'b0;
    fin_idx       = '0;

    case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (req_fire && (in_req.req_type == stbs_pkg::REQ_SEARCH)) begin
          lo_nxt  = start_sat;
          he_nxt  = end_sat;
          key_nxt = in_req.key_value;
          if (start_sat >= end_sat) begin
            finish = 1'b1;  // empty window: report not found at once
          end else begin
            state_nxt = stbs_pkg::ST_CMP;
          end
        end
      end
      stbs_pkg::ST_CMP: begin
        if ($signed(ram_rdata) == key_r) begin
          finish    = 1'b1;
          fin_found = 1'b1;
          fin_idx   = mid_r;
        end else begin
          if ($signed(ram_rdata) < key_r) begin
            lo_nxt = {1'b0, mid_r} + stbs_pkg::RNG_W'(1);
          end else begin
            he_nxt = {1'b0, mid_r};
          end
          if (lo_nxt >= he_nxt) begin
            finish = 1'b1;
          end
        end
      end
      stbs_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stbs_pkg::ST_IDLE;
      end
    endcase

    // Hand a finished result to the output register, or park it if occupied.
    if (finish) begin
      res_found_nxt = fin_found;
      res_idx_nxt   = fin_idx;
      state_nxt     = slot_free ? stbs_pkg::ST_IDLE : stbs_pkg::ST_DONE;
    end
  end

  // Advance the probe address while the window stays open; hold otherwise.
  always_comb begin
    mid_nxt = mid_r;
    if (state_nxt == stbs_pkg::ST_CMP) begin
      mid_nxt = mid_wide[stbs_pkg::IDX_W-1:0];
    end
  end

  // Output register: load from a fresh finish or from the parked result.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    if (finish && slot_free) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = fin_found;
      out_idx_nxt   = fin_idx;
    end else if ((state_r == stbs_pkg::ST_DONE) && slot_free) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res_found_r;
      out_idx_nxt   = res_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stbs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    he_r        <= he_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.found       = out_found_r;
  assign out_rsp.match_index = out_idx_r;

`ifndef ASSERT_OFF
  // A probe is only in flight on a non-empty window.
  a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stbs_pkg::ST_CMP) |-> (lo_r < he_r))
    else $error("probing an empty window");

  // The probed address lies inside the current window.
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stbs_pkg::ST_CMP) |-> (({1'b0, mid_r} >= lo_r) && ({1'b0, mid_r} < he_r)))
    else $error("probe address outside window");

  // A miss always reports index zero.
  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_idx_r == '0))
    else $error("miss reported with nonzero index");

  // A result is parked only while the output register is occupied.
  a_park_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stbs_pkg::ST_DONE) |-> out_valid_r)
    else $error("result parked with empty output register");
`endif

endmodule

`default_nettype wire

[rtl/stbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
